>>> design/dpu_pkg.sv
// Shared types, constants and lookup tables for the depth-to-point unprojection unit.
package dpu_pkg;

  // Fixed-point and datapath widths
  localparam int unsigned FracBits   = 16;
  localparam int unsigned ParamShift = 18;
  localparam int unsigned MmPerM     = 1000;
  localparam int unsigned DepthW     = 8;
  localparam int unsigned SideW      = 8;
  localparam int unsigned IdxW       = 16;
  localparam int unsigned RegW       = 31;
  localparam int unsigned MagW       = 31;
  localparam int unsigned DenW       = 41;
  localparam int unsigned ProdW      = MagW + DepthW;
  localparam int unsigned NumW       = 56;
  localparam int unsigned QuotW      = 32;
  localparam int unsigned CntW       = $clog2(QuotW);
  localparam int unsigned ZW         = 15;
  localparam int unsigned ColorW     = 8;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    CFG_FOCAL_X       = 3'd0,
    CFG_FOCAL_Y       = 3'd1,
    CFG_CENTER_U      = 3'd2,
    CFG_CENTER_V      = 3'd3,
    CFG_FRAME_COLUMNS = 3'd4,
    CFG_FRAME_ROWS    = 3'd5,
    CFG_VALID_SAMPLES = 3'd6
  } cfg_idx_e;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_MUL,
    BK_NUM,
    BK_DIV,
    BK_OUT
  } back_state_e;

  // Frame geometry seen by the front end
  typedef struct packed {
    logic [SideW-1:0] frame_columns;
    logic [SideW-1:0] frame_rows;
    logic [IdxW-1:0]  valid_samples;
  } geom_t;

  // Camera intrinsics seen by the back end
  typedef struct packed {
    logic [RegW-1:0] focal_x;
    logic [RegW-1:0] focal_y;
    logic [RegW-1:0] center_u;
    logic [RegW-1:0] center_v;
  } optics_t;

  // Classified pixel handed from front to back
  typedef struct packed {
    logic [DepthW-1:0] depth;
    logic [SideW-1:0]  col;
    logic [SideW-1:0]  row;
    logic              in_payload;
    logic              frame_end;
  } pixel_t;

  // One finished point
  typedef struct packed {
    logic [QuotW-1:0]  point_x;
    logic [QuotW-1:0]  point_y;
    logic [ZW-1:0]     point_z;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic              in_payload;
    logic              frame_end;
  } point_t;

  // Jet colormap, packed as {red, green, blue}
  function automatic logic [3*ColorW-1:0] jet_color(logic [DepthW-1:0] idx);
    logic [9:0] i;
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
    i = {2'b00, idx};
    if (i < 10'd32) begin
      r = 10'd128 + (i << 2);
      g = 10'd0;
      b = 10'd0;
    end else if (i < 10'd96) begin
      r = 10'd255;
      g = (i - 10'd32) << 2;
      b = 10'd0;
    end else if (i < 10'd160) begin
      r = 10'd254 - ((i - 10'd96) << 2);
      g = 10'd255;
      b = (i == 10'd96) ? 10'd1 : 10'd6 + ((i - 10'd97) << 2);
    end else if (i < 10'd224) begin
      r = 10'd0;
      g = 10'd252 - ((i - 10'd160) << 2);
      b = 10'd255;
    end else begin
      r = 10'd0;
      g = 10'd0;
      b = 10'd252 - ((i - 10'd224) << 2);
    end
    return {r[ColorW-1:0], g[ColorW-1:0], b[ColorW-1:0]};
  endfunction

  // Depth in metres, rounded: z = round(d * 2^FracBits / 1000)
  typedef logic [ZW-1:0] z_table_t [256];

  function automatic z_table_t build_z_table();
    z_table_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = ZW'((i * (1 << FracBits) + MmPerM / 2) / MmPerM);
    end
    return t;
  endfunction

  localparam z_table_t ZTable = build_z_table();

endpackage

>>> design/depth_to_point_unprojection_unit.sv
// Top level of the depth-to-point unprojection unit.
//
//   channel   direction  handshake        payload
//   input     in         push / full      depth_byte_i
//   result    out        empty / pop      point_x/y/z_o, red/green/blue_o,
//                                         in_payload_o, frame_end_o
//   config    in         cfg_we_i         cfg_addr_i, cfg_data_i
//
// A pixel inside the payload passes the back-end states in order: it is taken from the queue,
// operands are set up in three steps, the two restoring dividers for x and y run side by side
// (ending early when both quotients overflow) and the result is loaded; one outside skips to the load.
// A two-entry queue lets the front accept while the back works.
// Reset is asynchronous and active low; no memory clearing pass is needed.
// The result register holds a point until popped; the back end waits on it.
module depth_to_point_unprojection_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [dpu_pkg::DepthW-1:0]          depth_byte_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [dpu_pkg::QuotW-1:0]    point_x_o,
  output logic signed [dpu_pkg::QuotW-1:0]    point_y_o,
  output logic [dpu_pkg::ZW-1:0]              point_z_o,
  output logic [dpu_pkg::ColorW-1:0]          red_o,
  output logic [dpu_pkg::ColorW-1:0]          green_o,
  output logic [dpu_pkg::ColorW-1:0]          blue_o,
  output logic                                in_payload_o,
  output logic                                frame_end_o,
  input  logic                                cfg_we_i,
  input  logic [dpu_pkg::CfgAddrW-1:0]        cfg_addr_i,
  input  logic [dpu_pkg::RegW-1:0]            cfg_data_i
);

  logic [dpu_pkg::RegW-1:0]   focal_x_q, focal_y_q, center_u_q, center_v_q;
  logic [dpu_pkg::SideW-1:0]  frame_columns_q, frame_rows_q;
  logic [dpu_pkg::IdxW-1:0]   valid_samples_q;
  dpu_pkg::geom_t             geom;
  dpu_pkg::optics_t           optics;
  dpu_pkg::pixel_t            front_pixel;
  dpu_pkg::pixel_t            q_pixel;
  dpu_pkg::point_t            point;
  logic                       accept;
  logic                       q_empty;
  logic                       q_pop;

  // Decode configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q       <= '0;
      focal_y_q       <= '0;
      center_u_q      <= '0;
      center_v_q      <= '0;
      frame_columns_q <= dpu_pkg::SideW'(100);
      frame_rows_q    <= dpu_pkg::SideW'(100);
      valid_samples_q <= dpu_pkg::IdxW'(10000);
    end else if (cfg_we_i) begin
      unique case (dpu_pkg::cfg_idx_e'(cfg_addr_i))
        dpu_pkg::CFG_FOCAL_X:       focal_x_q       <= cfg_data_i;
        dpu_pkg::CFG_FOCAL_Y:       focal_y_q       <= cfg_data_i;
        dpu_pkg::CFG_CENTER_U:      center_u_q      <= cfg_data_i;
        dpu_pkg::CFG_CENTER_V:      center_v_q      <= cfg_data_i;
        dpu_pkg::CFG_FRAME_COLUMNS: frame_columns_q <= cfg_data_i[dpu_pkg::SideW-1:0];
        dpu_pkg::CFG_FRAME_ROWS:    frame_rows_q    <= cfg_data_i[dpu_pkg::SideW-1:0];
        dpu_pkg::CFG_VALID_SAMPLES: valid_samples_q <= cfg_data_i[dpu_pkg::IdxW-1:0];
        default: ;
      endcase
    end
  end

  assign geom.frame_columns = frame_columns_q;
  assign geom.frame_rows    = frame_rows_q;
  assign geom.valid_samples = valid_samples_q;
  assign optics.focal_x     = focal_x_q;
  assign optics.focal_y     = focal_y_q;
  assign optics.center_u    = center_u_q;
  assign optics.center_v    = center_v_q;

  assign accept = push && !full;

  dpu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .depth_i  (depth_byte_i),
    .geom_i   (geom),
    .pixel_o  (front_pixel)
  );

  dpu_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (front_pixel),
    .full_o    (full),
    .rd_en_i   (q_pop),
    .rd_data_o (q_pixel),
    .empty_o   (q_empty)
  );

  dpu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_pixel_i (q_pixel),
    .q_pop_o   (q_pop),
    .optics_i  (optics),
    .pop_i     (pop),
    .empty_o   (empty),
    .point_o   (point)
  );

  assign point_x_o    = point.point_x;
  assign point_y_o    = point.point_y;
  assign point_z_o    = point.point_z;
  assign red_o        = point.red;
  assign green_o      = point.green;
  assign blue_o       = point.blue;
  assign in_payload_o = point.in_payload;
  assign frame_end_o  = point.frame_end;

  // A point outside the payload carries no coordinates or colour
  a_zero_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !in_payload_o) |-> (point_x_o == '0 && point_y_o == '0 &&
      point_z_o == '0 && red_o == '0 && green_o == '0 && blue_o == '0))
    else $error("nonzero point outside payload");

  // Nonzero depth only comes from a payload pixel
  a_z_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && point_z_o != '0) |-> in_payload_o)
    else $error("depth set on a pixel outside payload");

  // Zero depth in the payload maps to the first colormap entry
  a_zero_depth_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && in_payload_o && point_z_o == '0) |->
      (red_o == 8'd128 && green_o == '0 && blue_o == '0))
    else $error("wrong colour for zero depth");

endmodule

>>> design/dpu_front.sv
// Front end: raster counters and per-pixel classification.
module dpu_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [dpu_pkg::DepthW-1:0] depth_i,
  input  dpu_pkg::geom_t        geom_i,
  output dpu_pkg::pixel_t       pixel_o
);

  logic [dpu_pkg::SideW-1:0] col_q, col_d;
  logic [dpu_pkg::SideW-1:0] row_q, row_d;
  logic [dpu_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [dpu_pkg::SideW-1:0] cols_eff;
  logic [dpu_pkg::SideW-1:0] rows_eff;
  logic                      last_col;
  logic                      last_row;

  // Treat a zero side as one
  assign cols_eff = (geom_i.frame_columns == '0) ? dpu_pkg::SideW'(1) : geom_i.frame_columns;
  assign rows_eff = (geom_i.frame_rows == '0) ? dpu_pkg::SideW'(1) : geom_i.frame_rows;

  // Classify the current position; a shrunk geometry ends the row at once
  assign last_col = ({1'b0, col_q} + 9'd1) >= {1'b0, cols_eff};
  assign last_row = ({1'b0, row_q} + 9'd1) >= {1'b0, rows_eff};

  assign pixel_o.depth      = depth_i;
  assign pixel_o.col        = col_q;
  assign pixel_o.row        = row_q;
  assign pixel_o.in_payload = idx_q < geom_i.valid_samples;
  assign pixel_o.frame_end  = last_col && last_row;

  // Advance counters on each accepted request
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    idx_d = idx_q;
    if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        if (last_row) begin
          row_d = '0;
          idx_d = '0;
        end else begin
          row_d = row_q + dpu_pkg::SideW'(1);
          idx_d = idx_q + dpu_pkg::IdxW'(1);
        end
      end else begin
        col_d = col_q + dpu_pkg::SideW'(1);
        idx_d = idx_q + dpu_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      idx_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      idx_q <= idx_d;
    end
  end

endmodule

>>> design/dpu_queue.sv
// Short queue of classified pixels between front and back end.
module dpu_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  dpu_pkg::pixel_t wr_data_i,
  output logic            full_o,
  input  logic            rd_en_i,
  output dpu_pkg::pixel_t rd_data_o,
  output logic            empty_o
);

  dpu_pkg::pixel_t                  mem_q [dpu_pkg::QueueDepth];
  logic [dpu_pkg::QueuePtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [dpu_pkg::QueuePtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [dpu_pkg::QueuePtrW:0]      count_q, count_d;
  logic                             do_wr;
  logic                             do_rd;

  assign full_o    = count_q == (dpu_pkg::QueuePtrW + 1)'(dpu_pkg::QueueDepth);
  assign empty_o   = count_q == '0;
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Move pointers and occupancy
  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + dpu_pkg::QueuePtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + dpu_pkg::QueuePtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + (dpu_pkg::QueuePtrW + 1)'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - (dpu_pkg::QueuePtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> design/dpu_div.sv
// Restoring divider, one quotient bit per cycle, with overflow detect.
module dpu_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dpu_pkg::NumW-1:0]    num_i,
  input  logic [dpu_pkg::DenW-1:0]    den_i,
  output logic                        done_o,
  output logic                        ovf_o,
  output logic [dpu_pkg::QuotW-1:0]   quot_o
);

  logic                             chk_q, chk_d;
  logic                             run_q, run_d;
  logic                             done_q, done_d;
  logic [dpu_pkg::CntW-1:0]         cnt_q, cnt_d;
  logic [dpu_pkg::NumW-1:0]         num_q;
  logic [dpu_pkg::DenW-1:0]         den_q;
  logic [dpu_pkg::DenW-1:0]         rem_q;
  logic [dpu_pkg::QuotW-1:0]        sh_q;
  logic                             ovf_q;
  logic [dpu_pkg::DenW-1:0]         num_hi;
  logic [dpu_pkg::DenW:0]           trial;
  logic [dpu_pkg::DenW:0]           diff;
  logic                             ge;

  assign num_hi = dpu_pkg::DenW'(num_q[dpu_pkg::NumW-1:dpu_pkg::QuotW]);
  assign trial  = {rem_q, sh_q[dpu_pkg::QuotW-1]};
  assign diff   = trial - {1'b0, den_q};
  assign ge     = trial >= {1'b0, den_q};

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quot_o = sh_q;

  // Sequence: load, overflow check, then one bit per cycle
  always_comb begin
    chk_d  = 1'b0;
    run_d  = run_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      chk_d  = 1'b1;
      run_d  = 1'b0;
      done_d = 1'b0;
    end else if (chk_q) begin
      cnt_d = '0;
      if (num_hi >= den_q) begin
        done_d = 1'b1;
      end else begin
        run_d = 1'b1;
      end
    end else if (run_q) begin
      cnt_d = cnt_q + dpu_pkg::CntW'(1);
      if (cnt_q == dpu_pkg::CntW'(dpu_pkg::QuotW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q  <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      chk_q  <= chk_d;
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
    end else if (chk_q) begin
      ovf_q <= num_hi >= den_q;
      rem_q <= num_hi;
      sh_q  <= num_q[dpu_pkg::QuotW-1:0];
    end else if (run_q) begin
      rem_q <= ge ? diff[dpu_pkg::DenW-1:0] : trial[dpu_pkg::DenW-1:0];
      sh_q  <= {sh_q[dpu_pkg::QuotW-2:0], ge};
    end
  end

endmodule

>>> design/dpu_back.sv
// Back end: projection arithmetic, colour lookup and result register.
module dpu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  dpu_pkg::pixel_t q_pixel_i,
  output logic            q_pop_o,
  input  dpu_pkg::optics_t optics_i,
  input  logic            pop_i,
  output logic            empty_o,
  output dpu_pkg::point_t point_o
);

  dpu_pkg::back_state_e          state_q, state_d;
  logic                          out_valid_q, out_valid_d;
  logic                          load_out;
  logic                          div_start;
  dpu_pkg::pixel_t               pix_q;
  dpu_pkg::point_t               res_q;
  logic                          neg_x_q, neg_y_q;
  logic [dpu_pkg::MagW-1:0]      mag_x_q, mag_y_q;
  logic [dpu_pkg::DenW-1:0]      den_x_q, den_y_q;
  logic [dpu_pkg::ProdW-1:0]     prod_x_q, prod_y_q;
  logic                          use_unit;
  logic [dpu_pkg::RegW-1:0]      fx, fy;
  logic [dpu_pkg::RegW-1:0]      ax, ay;
  logic [dpu_pkg::NumW-1:0]      num_x, num_y;
  logic                          done_x, done_y, ovf_x, ovf_y;
  logic [dpu_pkg::QuotW-1:0]     quot_x, quot_y;
  logic [3*dpu_pkg::ColorW-1:0]  rgb;
  dpu_pkg::point_t               res_d;

  // Clamp a quotient to the signed 32-bit range
  function automatic logic [dpu_pkg::QuotW-1:0] saturate(
    logic [dpu_pkg::QuotW-1:0] q, logic ovf, logic neg);
    logic [dpu_pkg::QuotW-1:0] r;
    if (!neg) begin
      r = (ovf || q[dpu_pkg::QuotW-1]) ? {1'b0, {(dpu_pkg::QuotW-1){1'b1}}} : q;
    end else if (ovf || (q > {1'b1, {(dpu_pkg::QuotW-1){1'b0}}})) begin
      r = {1'b1, {(dpu_pkg::QuotW-1){1'b0}}};
    end else begin
      r = ~q + dpu_pkg::QuotW'(1);
    end
    return r;
  endfunction

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dpu_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = q_pixel_i.in_payload ? dpu_pkg::BK_PREP : dpu_pkg::BK_OUT;
        end
      end
      dpu_pkg::BK_PREP: state_d = dpu_pkg::BK_MUL;
      dpu_pkg::BK_MUL:  state_d = dpu_pkg::BK_NUM;
      dpu_pkg::BK_NUM:  state_d = dpu_pkg::BK_DIV;
      dpu_pkg::BK_DIV: begin
        if (done_x && done_y) begin
          state_d = dpu_pkg::BK_OUT;
        end
      end
      dpu_pkg::BK_OUT: begin
        if (!out_valid_q || pop_i) begin
          state_d = dpu_pkg::BK_IDLE;
        end
      end
      default: state_d = dpu_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      dpu_pkg::BK_IDLE: q_pop_o   = !q_empty_i;
      dpu_pkg::BK_NUM:  div_start = 1'b1;
      dpu_pkg::BK_OUT:  load_out  = !out_valid_q || pop_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpu_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result until it is taken
  assign out_valid_d = load_out ? 1'b1 : (pop_i ? 1'b0 : out_valid_q);
  assign empty_o     = !out_valid_q;
  assign point_o     = res_q;

  // Substitute unit focal lengths when either is zero
  assign use_unit = (optics_i.focal_x == '0) || (optics_i.focal_y == '0);
  assign fx = use_unit ? dpu_pkg::RegW'(1 << dpu_pkg::ParamShift) : optics_i.focal_x;
  assign fy = use_unit ? dpu_pkg::RegW'(1 << dpu_pkg::ParamShift) : optics_i.focal_y;
  assign ax = dpu_pkg::RegW'(pix_q.col) << dpu_pkg::ParamShift;
  assign ay = dpu_pkg::RegW'(pix_q.row) << dpu_pkg::ParamShift;

  // Numerator with the rounding half of the denominator
  assign num_x = dpu_pkg::NumW'({prod_x_q, {dpu_pkg::FracBits{1'b0}}})
               + dpu_pkg::NumW'(den_x_q >> 1);
  assign num_y = dpu_pkg::NumW'({prod_y_q, {dpu_pkg::FracBits{1'b0}}})
               + dpu_pkg::NumW'(den_y_q >> 1);

  // Datapath registers, stepped by the sequencer
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pix_q <= q_pixel_i;
    end
    if (state_q == dpu_pkg::BK_PREP) begin
      neg_x_q <= ax < optics_i.center_u;
      neg_y_q <= ay < optics_i.center_v;
      mag_x_q <= (ax >= optics_i.center_u) ? ax - optics_i.center_u : optics_i.center_u - ax;
      mag_y_q <= (ay >= optics_i.center_v) ? ay - optics_i.center_v : optics_i.center_v - ay;
      den_x_q <= dpu_pkg::DenW'(fx) * dpu_pkg::DenW'(dpu_pkg::MmPerM);
      den_y_q <= dpu_pkg::DenW'(fy) * dpu_pkg::DenW'(dpu_pkg::MmPerM);
    end
    if (state_q == dpu_pkg::BK_MUL) begin
      prod_x_q <= dpu_pkg::ProdW'(pix_q.depth) * dpu_pkg::ProdW'(mag_x_q);
      prod_y_q <= dpu_pkg::ProdW'(pix_q.depth) * dpu_pkg::ProdW'(mag_y_q);
    end
    if (load_out) begin
      res_q <= res_d;
    end
  end

  // Assemble the point; outside the payload only the frame mark survives
  assign rgb = dpu_pkg::jet_color(pix_q.depth);

  always_comb begin
    res_d            = '0;
    res_d.frame_end  = pix_q.frame_end;
    if (pix_q.in_payload) begin
      res_d.point_x    = saturate(quot_x, ovf_x, neg_x_q);
      res_d.point_y    = saturate(quot_y, ovf_y, neg_y_q);
      res_d.point_z    = dpu_pkg::ZTable[pix_q.depth];
      res_d.red        = rgb[3*dpu_pkg::ColorW-1:2*dpu_pkg::ColorW];
      res_d.green      = rgb[2*dpu_pkg::ColorW-1:dpu_pkg::ColorW];
      res_d.blue       = rgb[dpu_pkg::ColorW-1:0];
      res_d.in_payload = 1'b1;
    end
  end

  dpu_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_x),
    .den_i   (den_x_q),
    .done_o  (done_x),
    .ovf_o   (ovf_x),
    .quot_o  (quot_x)
  );

  dpu_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_y),
    .den_i   (den_y_q),
    .done_o  (done_y),
    .ovf_o   (ovf_y),
    .quot_o  (quot_y)
  );

endmodule
